### design/image_rotation_nearest_macros.svh
// Assertion macros for the image rotation block.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef IMAGE_ROTATION_NEAREST_MACROS_SVH
`define IMAGE_ROTATION_NEAREST_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge, masked while reset is asserted.
`define IRN_CHECK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define IRN_CHECK_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IRN_CHECK(name, prop, msg)
`define IRN_CHECK_ALWAYS(name, prop, msg)
`endif
`endif

### design/imgrot_pkg.sv
// Shared types, widths and helpers for the image rotation block.
// No dependencies; used by imgrot_map and image_rotation_nearest.
package imgrot_pkg;

    localparam int FRAC   = 14;           // Q2.14 fraction bits
    localparam int DW     = 10;           // offset from centre, signed
    localparam int BW     = 11;           // centre plus shift, signed
    localparam int PW     = 26;           // DW x 16-bit product
    localparam int SW     = 28;           // accumulated mapping sum
    localparam int QW     = SW - FRAC;    // mapped source coordinate
    localparam int TRIGW  = 16;
    localparam int SHIFTW = 10;
    localparam int SIZEW  = 9;

    typedef struct packed {
        logic                     start;
        logic signed [DW-1:0]     dx;
        logic signed [DW-1:0]     dy;
        logic signed [BW-1:0]     base_x;
        logic signed [BW-1:0]     base_y;
        logic signed [TRIGW-1:0]  sine;
        logic signed [TRIGW-1:0]  cosine;
        logic [SIZEW-1:0]         cols;
        logic [SIZEW-1:0]         rows;
    } t_map_req;

    typedef struct packed {
        logic                  done;
        logic                  in_frame;
        logic signed [QW-1:0]  nx;
        logic signed [QW-1:0]  ny;
    } t_map_res;

    // Divide by 2^FRAC, rounding toward zero.
    function automatic logic signed [QW-1:0] f_trunc_q(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v + (v[SW-1] ? SW'((1 << FRAC) - 1) : SW'(0));
        return t[SW-1:FRAC];
    endfunction

endpackage

### design/imgrot_map.sv
// Inverse rotation of one output coordinate into the source frame.
// Three registered stages: products, sums, truncate and bounds check. Uses imgrot_pkg.
module imgrot_map (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imgrot_pkg::t_map_req i_req,
    output imgrot_pkg::t_map_res o_res
);

    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;
    logic signed [imgrot_pkg::PW-1:0]    r_pxc;
    logic signed [imgrot_pkg::PW-1:0]    r_pys;
    logic signed [imgrot_pkg::PW-1:0]    r_pxs;
    logic signed [imgrot_pkg::PW-1:0]    r_pyc;
    logic signed [imgrot_pkg::BW-1:0]    r_bx;
    logic signed [imgrot_pkg::BW-1:0]    r_by;
    logic signed [imgrot_pkg::SW-1:0]    r_sum_x;
    logic signed [imgrot_pkg::SW-1:0]    r_sum_y;
    logic signed [imgrot_pkg::QW-1:0]    r_nx;
    logic signed [imgrot_pkg::QW-1:0]    r_ny;
    logic                                r_inside;
    logic signed [imgrot_pkg::QW-1:0]    q_x;
    logic signed [imgrot_pkg::QW-1:0]    q_y;
    logic                                in_x;
    logic                                in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1: the four products of the rotation matrix.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_pxc <= imgrot_pkg::PW'(i_req.dx) * imgrot_pkg::PW'(i_req.cosine);
            r_pys <= imgrot_pkg::PW'(i_req.dy) * imgrot_pkg::PW'(i_req.sine);
            r_pxs <= imgrot_pkg::PW'(i_req.dx) * imgrot_pkg::PW'(i_req.sine);
            r_pyc <= imgrot_pkg::PW'(i_req.dy) * imgrot_pkg::PW'(i_req.cosine);
            r_bx  <= i_req.base_x;
            r_by  <= i_req.base_y;
        end
    end

    // Stage 2: centre term plus rotated offset, still in Q.14.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_sum_x <= (imgrot_pkg::SW'(r_bx) <<< imgrot_pkg::FRAC)
                       + imgrot_pkg::SW'(r_pxc) + imgrot_pkg::SW'(r_pys);
            r_sum_y <= (imgrot_pkg::SW'(r_by) <<< imgrot_pkg::FRAC)
                       - imgrot_pkg::SW'(r_pxs) + imgrot_pkg::SW'(r_pyc);
        end
    end

    // Stage 3: truncate toward zero and check against the frame in use.
    always_comb begin
        q_x  = imgrot_pkg::f_trunc_q(r_sum_x);
        q_y  = imgrot_pkg::f_trunc_q(r_sum_y);
        in_x = !q_x[imgrot_pkg::QW-1]
               && (q_x[imgrot_pkg::QW-2:0] < (imgrot_pkg::QW-1)'(i_req.cols));
        in_y = !q_y[imgrot_pkg::QW-1]
               && (q_y[imgrot_pkg::QW-2:0] < (imgrot_pkg::QW-1)'(i_req.rows));
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_nx     <= q_x;
            r_ny     <= q_y;
            r_inside <= in_x && in_y;
        end
    end

    assign o_res.done     = r_v3;
    assign o_res.in_frame = r_inside;
    assign o_res.nx       = r_nx;
    assign o_res.ny       = r_ny;

endmodule

### design/image_rotation_nearest.sv
// Top level of the nearest-neighbor image rotation block: frame store and control.
// Depends on imgrot_pkg, imgrot_map and image_rotation_nearest_macros.svh.
//
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+----------------------------------
// s        | in        | i_s_tvalid / o_s_tready   | tdata row,col,pixel; tuser op
// m        | out       | o_m_tvalid / i_m_tready   | tdata pixel_out; tuser inside
// cfg      | in        | i_cfg_valid / o_cfg_ready | index + 16-bit data
//
// Writes are taken back to back while idle, one word per cycle. A read is taken only when
// idle and goes through the three mapping stages, the first on the taking edge, then the
// frame-store read and the output load; no new word is taken until the output is loaded.
// Reset is synchronous, active low; the frame store has no reset and no clearing pass.
// A stalled output holds its word; a finished read then holds in its own register and
// blocks the input until the output word is taken.
`include "image_rotation_nearest_macros.svh"

module image_rotation_nearest #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] row_index, [15:8] col_index, [23:16] pixel_in
    input  logic        i_s_tuser,   // [0] operation
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] pixel_out
    output logic        o_m_tuser,   // [0] inside_frame
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] REG_SINE   = 3'd0;
    localparam logic [2:0] REG_COSINE = 3'd1;
    localparam logic [2:0] REG_SHIFTX = 3'd2;
    localparam logic [2:0] REG_SHIFTY = 3'd3;
    localparam logic [2:0] REG_COLS   = 3'd4;
    localparam logic [2:0] REG_ROWS   = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAP  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // configuration
    logic signed [imgrot_pkg::TRIGW-1:0]  r_sine;
    logic signed [imgrot_pkg::TRIGW-1:0]  r_cosine;
    logic signed [imgrot_pkg::SHIFTW-1:0] r_shift_x;
    logic signed [imgrot_pkg::SHIFTW-1:0] r_shift_y;
    logic [imgrot_pkg::SIZEW-1:0]         r_frame_cols;
    logic [imgrot_pkg::SIZEW-1:0]         r_frame_rows;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [7:0]  r_frame_mem [DEPTH];
    logic [7:0]  r_rd_pixel;
    logic        r_rd_inside;
    logic        r_out_valid;
    logic [7:0]  r_out_pixel;
    logic        r_out_inside;

    logic [7:0]                   in_row;
    logic [7:0]                   in_col;
    logic [7:0]                   in_pixel;
    logic                         s_accept;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic                         rd_en;
    logic                         out_load;
    logic [imgrot_pkg::SIZEW-1:0] cols;
    logic [imgrot_pkg::SIZEW-1:0] rows;
    logic [7:0]                   c0;
    logic [7:0]                   r0;
    imgrot_pkg::t_map_req         map_req;
    imgrot_pkg::t_map_res         map_res;

    assign in_row   = i_s_tdata[7:0];
    assign in_col   = i_s_tdata[15:8];
    assign in_pixel = i_s_tdata[23:16];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;

    // register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sine       <= '0;
            r_cosine     <= imgrot_pkg::TRIGW'(1 << imgrot_pkg::FRAC);
            r_shift_x    <= '0;
            r_shift_y    <= '0;
            r_frame_cols <= imgrot_pkg::SIZEW'(256);
            r_frame_rows <= imgrot_pkg::SIZEW'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SINE:   r_sine       <= i_cfg_data;
                REG_COSINE: r_cosine     <= i_cfg_data;
                REG_SHIFTX: r_shift_x    <= i_cfg_data[imgrot_pkg::SHIFTW-1:0];
                REG_SHIFTY: r_shift_y    <= i_cfg_data[imgrot_pkg::SHIFTW-1:0];
                REG_COLS:   r_frame_cols <= i_cfg_data[imgrot_pkg::SIZEW-1:0];
                REG_ROWS:   r_frame_rows <= i_cfg_data[imgrot_pkg::SIZEW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame to the store, then take the truncated centre.
    always_comb begin
        cols = (32'(r_frame_cols) > 32'(MAX_WIDTH))
               ? imgrot_pkg::SIZEW'(MAX_WIDTH) : r_frame_cols;
        rows = (32'(r_frame_rows) > 32'(MAX_HEIGHT))
               ? imgrot_pkg::SIZEW'(MAX_HEIGHT) : r_frame_rows;
        c0   = cols[imgrot_pkg::SIZEW-1:1];
        r0   = rows[imgrot_pkg::SIZEW-1:1];
    end

    // Mapping request: offsets from the centre and the shifted centre.
    always_comb begin
        map_req.start  = s_accept && (i_s_tuser == OP_READ);
        map_req.dx     = $signed({2'b00, in_col}) - $signed({2'b00, c0});
        map_req.dy     = $signed({2'b00, in_row}) - $signed({2'b00, r0});
        map_req.base_x = $signed({3'b000, c0}) + imgrot_pkg::BW'(r_shift_x);
        map_req.base_y = $signed({3'b000, r0}) + imgrot_pkg::BW'(r_shift_y);
        map_req.sine   = r_sine;
        map_req.cosine = r_cosine;
        map_req.cols   = cols;
        map_req.rows   = rows;
    end

    imgrot_map u_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (map_req),
        .o_res  (map_res)
    );

    // Frame store: write straight from the input word, read once per mapped read that lands inside.
    assign wr_en   = s_accept && (i_s_tuser == OP_WRITE)
                     && (32'(in_col) < 32'(MAX_WIDTH)) && (32'(in_row) < 32'(MAX_HEIGHT));
    assign wr_addr = AW'(32'(in_row) * 32'(MAX_WIDTH) + 32'(in_col));
    assign rd_addr = AW'(map_res.ny[RW-1:0]) * AW'(MAX_WIDTH) + AW'(map_res.nx[CW-1:0]);
    assign rd_en   = (r_state == ST_MAP) && map_res.done && map_res.in_frame;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame_mem[wr_addr] <= in_pixel;
        end
        if (rd_en) begin
            r_rd_pixel <= r_frame_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_MAP) && map_res.done) begin
            r_rd_inside <= map_res.in_frame;
        end
    end

    // Sequencer: idle takes words, map waits for the pipeline, out loads the result.
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (map_req.start) n_state = ST_MAP;
            ST_MAP:  if (map_res.done)  n_state = ST_OUT;
            ST_OUT:  if (out_load)      n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: hold while stalled, advance when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pixel  <= r_rd_inside ? r_rd_pixel : 8'd0;
            r_out_inside <= r_rd_inside;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;
    assign o_m_tuser  = r_out_inside;

    `IRN_CHECK(a_done_in_map, map_res.done |-> (r_state == ST_MAP), "mapping result outside map state")
    `IRN_CHECK(a_start_idle, map_req.start |-> (r_state == ST_IDLE), "read started while busy")
    `IRN_CHECK(a_out_zero, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 8'd0),
               "outside pixel not zero")
    `IRN_CHECK(a_rise_from_out, $rose(r_out_valid) |-> ($past(r_state) == ST_OUT),
               "result without read")
    `IRN_CHECK(a_out_after_done,
               ((r_state == ST_OUT) && ($past(r_state) == ST_MAP)) |-> $past(map_res.done),
               "left map early")

endmodule

### verif/tb_image_rotation_nearest.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_rotation_nearest: loads source pixels, reads
// rotated pixels back and compares each output word with an in-bench predictor.
// Depends only on the RTL (image_rotation_nearest and its package and submodules).

module tb_image_rotation_nearest;

    localparam int     FRAME_MAX      = 256;    // store is FRAME_MAX x FRAME_MAX
    localparam longint Q_ONE          = 16384;  // 1.0 in Q2.14
    localparam int     WORD_TARGET    = 1250;   // minimum input words to send in total
    localparam int     QUIET_FROM     = 1050;   // no idling on either side after this
    localparam int     SETTLE_CYCLES  = 8;      // let a trailing pixel write land
    localparam int     TAIL_CYCLES    = 20;     // watch for stray output words at the end
    localparam int     WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
    localparam int     REPORT_LIMIT   = 10;

    typedef enum logic {OP_WRITE, OP_READ} pixel_op_e;

    typedef enum logic [2:0] {
        REG_SINE, REG_COSINE, REG_SHIFT_X, REG_SHIFT_Y,
        REG_COLS, REG_ROWS, REG_SPARE_6, REG_SPARE_7
    } cfg_reg_e;

    typedef struct packed {
        logic [7:0] pixel;
        logic       in_frame;
    } rotated_pixel_t;

    // Tracks the source frame and the registers, predicts every rotated read and
    // checks the output words in order.
    class rotated_pixel_tracker;
        bit [7:0]           frame_mem [FRAME_MAX*FRAME_MAX];
        bit                 written   [FRAME_MAX*FRAME_MAX];
        logic signed [15:0] sine_reg;
        logic signed [15:0] cosine_reg;
        logic signed [9:0]  shift_x_reg;
        logic signed [9:0]  shift_y_reg;
        logic [8:0]         cols_reg;
        logic [8:0]         rows_reg;
        rotated_pixel_t     expected_pixels[$];
        int unsigned        mismatches;
        int unsigned        writes_seen;
        int unsigned        reads_seen;
        int unsigned        outside_seen;
        int unsigned        words_checked;

        function new();
            sine_reg      = 16'sd0;
            cosine_reg    = 16'sd16384;
            shift_x_reg   = 10'sd0;
            shift_y_reg   = 10'sd0;
            cols_reg      = 9'd256;
            rows_reg      = 9'd256;
            mismatches    = 0;
            writes_seen   = 0;
            reads_seen    = 0;
            outside_seen  = 0;
            words_checked = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [15:0] data);
            case (idx)
                REG_SINE:    sine_reg    = data;
                REG_COSINE:  cosine_reg  = data;
                REG_SHIFT_X: shift_x_reg = data[9:0];
                REG_SHIFT_Y: shift_y_reg = data[9:0];
                REG_COLS:    cols_reg    = data[8:0];
                REG_ROWS:    rows_reg    = data[8:0];
                default: ;  // spare indexes change nothing
            endcase
        endfunction

        // Map an output coordinate back into the source frame: rotate about the
        // centre of the frame in use, add the offset, truncate toward zero.
        function void locate_source(input int row, input int col,
                                    output longint src_row, output longint src_col,
                                    output bit in_frame);
            longint eff_cols, eff_rows, r0, c0, dx, dy;
            eff_cols = (cols_reg > 9'd256) ? longint'(FRAME_MAX) : longint'(cols_reg);
            eff_rows = (rows_reg > 9'd256) ? longint'(FRAME_MAX) : longint'(rows_reg);
            r0 = eff_rows / 2;
            c0 = eff_cols / 2;
            dx = longint'(col) - c0;
            dy = longint'(row) - r0;
            src_row = ((r0 + longint'(shift_y_reg)) * Q_ONE - dx * longint'(sine_reg)
                       + dy * longint'(cosine_reg)) / Q_ONE;
            src_col = ((c0 + longint'(shift_x_reg)) * Q_ONE + dx * longint'(cosine_reg)
                       + dy * longint'(sine_reg)) / Q_ONE;
            in_frame = (src_col >= 0) && (src_row >= 0)
                       && (src_col < eff_cols) && (src_row < eff_rows);
        endfunction

        function bit is_written(longint src_row, longint src_col);
            return written[src_row * FRAME_MAX + src_col];
        endfunction

        // Note one accepted input word: store a pixel or queue the rotated result.
        function void note_word(pixel_op_e op, logic [7:0] row, logic [7:0] col,
                                logic [7:0] pix);
            longint         src_row, src_col;
            bit             hit;
            rotated_pixel_t want;
            if (op == OP_WRITE) begin
                frame_mem[row * FRAME_MAX + col] = pix;
                written[row * FRAME_MAX + col]   = 1'b1;
                writes_seen++;
            end else begin
                locate_source(row, col, src_row, src_col, hit);
                want.in_frame = hit;
                want.pixel    = hit ? frame_mem[src_row * FRAME_MAX + src_col] : 8'd0;
                expected_pixels.push_back(want);
                reads_seen++;
                if (!hit)
                    outside_seen++;
            end
        endfunction

        // Check one accepted output word against the oldest queued read.
        function void check_pixel(logic [7:0] pixel, logic in_frame_bit);
            rotated_pixel_t want;
            words_checked++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] output word with no read pending: pixel %0d in_frame %0b",
                             $time, pixel, in_frame_bit);
                return;
            end
            want = expected_pixels.pop_front();
            if (pixel !== want.pixel || in_frame_bit !== want.in_frame) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] output word %0d: pixel exp %0d got %0d, in_frame exp %0b got %0b",
                             $time, words_checked, want.pixel, pixel, want.in_frame,
                             in_frame_bit);
            end
        endfunction

        function bit has_pending();
            return expected_pixels.size() != 0;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;    // [7:0] row_index, [15:8] col_index, [23:16] pixel_in
    logic        i_s_tuser;    // [0] operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;    // [7:0] pixel_out
    logic        o_m_tuser;    // [0] inside_frame
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    rotated_pixel_tracker pixel_tracker;
    bit                   idle_on;        // random idling on both sides
    int unsigned          words_sent;
    int unsigned          settings_used;
    int unsigned          quiet_cycles;

    image_rotation_nearest dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Send one word on the input stream. Start and end at a falling edge; leave
    // tvalid high on return so that a back-to-back word needs no second
    // assignment in the same step. Callers that pause lower it first.
    task automatic send_word(pixel_op_e op, logic [7:0] row, logic [7:0] col,
                             logic [7:0] pix);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {pix, col, row};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pixel_tracker.note_word(op, row, col, pix);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Read a rotated pixel. Where it maps onto a store entry that was never
    // written, write that entry first so that no undefined entry is ever read.
    task automatic read_pixel(logic [7:0] row, logic [7:0] col);
        longint src_row, src_col;
        bit     hit;
        pixel_tracker.locate_source(row, col, src_row, src_col, hit);
        if (hit && !pixel_tracker.is_written(src_row, src_col))
            send_word(OP_WRITE, 8'(src_row), 8'(src_col), 8'($urandom));
        send_word(OP_READ, row, col, 8'($urandom));
    endtask

    // Hold the input stream until every queued read has come back, then let a
    // trailing write settle. Always advances time.
    task automatic drain_reads();
        i_s_tvalid <= 1'b0;
        while (pixel_tracker.has_pending())
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register; i_cfg_valid stays high on return, as tvalid does on the input stream.
    task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        pixel_tracker.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Program all six registers; the block must be idle. Now and then throw in
    // a write to a spare index, which must change nothing.
    task automatic program_frame(logic [15:0] sn, logic [15:0] cs, logic [15:0] sx,
                                 logic [15:0] sy, logic [15:0] cols, logic [15:0] rows);
        write_reg(REG_SINE, sn);
        write_reg(REG_COSINE, cs);
        write_reg(REG_SHIFT_X, sx);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Output side: check every accepted word at the rising edge; pick tready at
    // the falling edge, with random stall bursts while idling is on.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                pixel_tracker.check_pixel(o_m_tdata, o_m_tuser);
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no handshake of any kind happens for too long.
    initial begin
        quiet_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles, %0d reads still pending",
                 WATCHDOG_LIMIT, pixel_tracker.expected_pixels.size());
        $display("Mismatches found");
        $finish;
    end

    // Stimulus.
    initial begin
        int          burst;
        int          pick;
        int          eff_cols;
        int          eff_rows;
        real         angle;
        logic [15:0] sn_w, cs_w, sx_w, sy_w, cols_w, rows_w;

        pixel_tracker = new();
        idle_on       = 1'b1;
        words_sent    = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Reset values give the identity mapping on a full frame:
        // load the four corners with extreme pixels and read them straight back.
        send_word(OP_WRITE, 8'd0,   8'd0,   8'hFF);
        send_word(OP_WRITE, 8'd255, 8'd255, 8'h00);
        send_word(OP_WRITE, 8'd0,   8'd255, 8'hA5);
        send_word(OP_WRITE, 8'd255, 8'd0,   8'h5A);
        read_pixel(8'd0,   8'd0);
        read_pixel(8'd255, 8'd255);
        read_pixel(8'd0,   8'd255);
        read_pixel(8'd255, 8'd0);

        // Frame size above the store: it must saturate to 256, so a one-column
        // shift pushes the last column out and keeps the one before it in.
        drain_reads();
        program_frame(16'd0, 16'd16384, 16'd1, 16'd0, 16'hFFFF, 16'd300);
        read_pixel(8'd0, 8'd255);
        read_pixel(8'd0, 8'd254);

        // No columns in use: nothing is inside.
        drain_reads();
        program_frame(16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd256);
        read_pixel(8'd0, 8'd0);

        // Raw trig values past +-1.0 on a small frame.
        drain_reads();
        program_frame(16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd16, 16'd16);
        read_pixel(8'd3, 8'd5);
        read_pixel(8'd8, 8'd8);

        // Spare register indexes must be ignored; then read far outside a 16x16
        // frame with large negative offsets that land one read back inside.
        drain_reads();
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hFFFF);
        program_frame(16'd0, 16'd16384, -16'sd190, -16'sd190, 16'd16, 16'd16);
        read_pixel(8'd200, 8'd200);
        read_pixel(8'd200, 8'd180);

        // Random part: a fresh register setting per burst, then mostly reads near
        // the frame in use (each preceded by the write it needs), some reads over
        // the whole coordinate range, and stray writes anywhere in the store.
        while (words_sent < WORD_TARGET) begin
            drain_reads();
            case ($urandom_range(0, 5))
                0: begin sn_w = 16'd0;      cs_w = 16'd16384;  end
                1: begin sn_w = 16'd16384;  cs_w = 16'd0;      end
                2: begin sn_w = -16'sd16384; cs_w = -16'sd16384; end
                3, 4: begin
                    angle = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                    sn_w  = 16'($rtoi($sin(angle) * 16384.0));
                    cs_w  = 16'($rtoi($cos(angle) * 16384.0));
                end
                default: begin sn_w = 16'($urandom); cs_w = 16'($urandom); end
            endcase
            case ($urandom_range(0, 4))
                0:       begin sx_w = 16'd0; sy_w = 16'd0; end
                1, 2:    begin
                    sx_w = 16'($urandom_range(0, 12)) - 16'd6;
                    sy_w = 16'($urandom_range(0, 12)) - 16'd6;
                end
                3:       begin sx_w = 16'($urandom); sy_w = 16'($urandom); end
                default: begin
                    sx_w = $urandom_range(0, 1) ? 16'd511 : -16'sd512;
                    sy_w = $urandom_range(0, 1) ? 16'd511 : -16'sd512;
                end
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    cols_w = 16'($urandom_range(1, 24));
                    rows_w = 16'($urandom_range(1, 24));
                end
                4:       begin cols_w = 16'd1;   rows_w = 16'($urandom_range(1, 8)); end
                5:       begin cols_w = 16'd256; rows_w = 16'd256; end
                6:       begin cols_w = 16'($urandom); rows_w = 16'($urandom); end
                default: begin
                    cols_w = 16'($urandom_range(2, 64));
                    rows_w = 16'($urandom_range(2, 64));
                end
            endcase
            program_frame(sn_w, cs_w, sx_w, sy_w, cols_w, rows_w);

            // Aim most reads a little past the frame in use.
            eff_cols = (cols_w[8:0] > 9'd256) ? FRAME_MAX : int'(cols_w[8:0]);
            eff_rows = (rows_w[8:0] > 9'd256) ? FRAME_MAX : int'(rows_w[8:0]);
            eff_cols = (eff_cols + 3 > 255) ? 255 : eff_cols + 3;
            eff_rows = (eff_rows + 3 > 255) ? 255 : eff_rows + 3;

            burst = $urandom_range(40, 110);
            repeat (burst) begin
                if (words_sent >= QUIET_FROM)
                    idle_on = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    drain_reads();
                else if (pick < 20)
                    send_word(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
                else if (pick < 32)
                    read_pixel(8'($urandom), 8'($urandom));
                else
                    read_pixel(8'($urandom_range(0, eff_rows)),
                               8'($urandom_range(0, eff_cols)));
            end
        end

        // Hold the input, wait for every read to come back, then watch a while
        // longer for stray output words.
        i_s_tvalid <= 1'b0;
        while (pixel_tracker.has_pending())
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d pixel writes and %0d rotated reads (%0d mapped outside) over %0d register settings",
                 pixel_tracker.writes_seen, pixel_tracker.reads_seen,
                 pixel_tracker.outside_seen, settings_used);
        $display("Output words checked: %0d, mismatching: %0d",
                 pixel_tracker.words_checked, pixel_tracker.mismatches);
        if (pixel_tracker.mismatches == 0 && !pixel_tracker.has_pending())
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
